/* rtl/dfbd_pkg.sv */
// Shared types and constants of the dual-frame byte deframer.
`timescale 1ns / 1ps
`default_nettype none

package dfbd_pkg;

   // Frame delimiters on the serial link.
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   // Input operation codes.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_ARM  = 1'b1;

   // Buffer limits, in stored bytes.
   localparam logic [6:0] SERVICE_LIMIT = 7'd106;
   localparam logic [3:0] KEYPAD_LIMIT  = 4'd15;

   // Configuration register indexes and address width.
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_NETWORK_MODE  = 1'b0;
   localparam logic REG_MULTI_SERVICE = 1'b1;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // A classified input word.
   typedef struct packed {
      logic       arm;
      logic       is_dollar;
      logic       is_hash;
      logic       is_star;
      logic [7:0] rx_byte;
   } cmd_type;

   // Push side of the queue.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   // Head of the queue as seen by the back part.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // Configuration as seen by the back part.
   typedef struct packed {
      logic network_mode;
      logic multi_service;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/dfbd_ifs.sv */
// Valid/ready channel interfaces of the deframer's input and result sides.
`timescale 1ns / 1ps
`default_nettype none

interface dfbd_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] rx_byte;

   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface dfbd_rsp_if;
   logic       valid;
   logic       ready;
   logic       service_write;
   logic       keypad_write;
   logic [6:0] write_index;
   logic [7:0] write_byte;
   logic       service_done;
   logic       keypad_done;
   logic       service_open;
   logic       keypad_open;

   modport source (output valid, output service_write, output keypad_write,
                   output write_index, output write_byte, output service_done,
                   output keypad_done, output service_open, output keypad_open,
                   input ready);
   modport sink   (input valid, input service_write, input keypad_write,
                   input write_index, input write_byte, input service_done,
                   input keypad_done, input service_open, input keypad_open,
                   output ready);
endinterface

`default_nettype wire

/* rtl/dfbd_queue.sv */
// Short queue of classified words between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module dfbd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dfbd_pkg::push_type push,
   output logic                   not_full,
   output dfbd_pkg::head_type     head,
   input  wire logic              pop
);

   dfbd_pkg::cmd_type                          entry_ff [dfbd_pkg::QUEUE_DEPTH];
   logic [dfbd_pkg::QUEUE_PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [dfbd_pkg::QUEUE_PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [dfbd_pkg::QUEUE_CNT_W-1:0]           count_ff, count_in;
   logic                                       do_pop;

   assign not_full   = (count_ff != dfbd_pkg::QUEUE_CNT_W'(dfbd_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; no reset needed on payload.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   // The fill count never runs past the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= dfbd_pkg::QUEUE_CNT_W'(dfbd_pkg::QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   // Entries sit between the read and write pointers.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == dfbd_pkg::QUEUE_CNT_W'(dfbd_pkg::QUEUE_DEPTH))
      == (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

   // A push is never taken while the queue is full.
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> not_full)
      else $error("push into full queue");

endmodule

`default_nettype wire

/* rtl/dfbd_front.sv */
// Front part: accepts input words, classifies them and fills the queue.
`timescale 1ns / 1ps
`default_nettype none

module dfbd_front (
   dfbd_req_if.sink               req_ch,
   input  wire logic              not_full,
   output dfbd_pkg::push_type     push
);

   // Ready follows queue space only, so words keep flowing while results wait.
   assign req_ch.ready = not_full;

   // Classify the byte once, so the back part only tests flags.
   always_comb begin
      push.valid         = req_ch.valid && not_full;
      push.cmd.arm       = (req_ch.operation == dfbd_pkg::OP_ARM);
      push.cmd.is_dollar = (req_ch.rx_byte == dfbd_pkg::CH_DOLLAR);
      push.cmd.is_hash   = (req_ch.rx_byte == dfbd_pkg::CH_HASH);
      push.cmd.is_star   = (req_ch.rx_byte == dfbd_pkg::CH_STAR);
      push.cmd.rx_byte   = req_ch.rx_byte;
   end

endmodule

`default_nettype wire

/* rtl/dfbd_back.sv */
// Back part: frame state machine and registered result word.
`timescale 1ns / 1ps
`default_nettype none

module dfbd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dfbd_pkg::cfg_type cfg,
   input  wire dfbd_pkg::head_type head,
   output logic                   pop,
   dfbd_rsp_if.source             rsp_ch
);

   // Frame state.
   logic       svc_open_ff, svc_open_in;
   logic       svc_done_ff, svc_done_in;
   logic [6:0] svc_count_ff, svc_count_in;
   logic       kp_open_ff, kp_open_in;
   logic       kp_done_ff, kp_done_in;
   logic [3:0] kp_count_ff, kp_count_in;
   logic       restart_ff, restart_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       svc_wr_ff, svc_wr_in;
   logic       kp_wr_ff, kp_wr_in;
   logic [6:0] index_ff, index_in;
   logic [7:0] byte_ff, byte_in;

   // Take the head word whenever the result register is free or being drained.
   assign pop = head.valid && (!rsp_valid_ff || rsp_ch.ready);

   // Next frame state and strobes for the head word.
   always_comb begin
      svc_open_in  = svc_open_ff;
      svc_done_in  = svc_done_ff;
      svc_count_in = svc_count_ff;
      kp_open_in   = kp_open_ff;
      kp_done_in   = kp_done_ff;
      kp_count_in  = kp_count_ff;
      restart_in   = restart_ff;
      svc_wr_in    = 1'b0;
      kp_wr_in     = 1'b0;
      index_in     = '0;
      byte_in      = '0;
      if (head.cmd.arm) begin
         restart_in = 1'b1;
      end else begin
         // A dollar sign opens a new service range.
         if (head.cmd.is_dollar) begin
            svc_open_in  = 1'b1;
            svc_done_in  = 1'b0;
            svc_count_in = '0;
         end
         if (cfg.multi_service && svc_open_in) begin
            // Stored service frame: a hash after stored bytes closes it.
            if (head.cmd.is_hash && svc_count_in != '0) begin
               svc_done_in = 1'b1;
               svc_open_in = 1'b0;
            end
            if (svc_open_in && svc_count_in < dfbd_pkg::SERVICE_LIMIT) begin
               svc_wr_in    = 1'b1;
               index_in     = svc_count_in;
               byte_in      = head.cmd.rx_byte;
               svc_count_in = svc_count_in + 1'b1;
            end
         end else if (!svc_open_in) begin
            // Keypad frame: restart on request or on star in network mode.
            if (restart_ff || (cfg.network_mode && head.cmd.is_star)) begin
               restart_in  = 1'b0;
               kp_count_in = '0;
               kp_open_in  = 1'b1;
               kp_done_in  = 1'b0;
            end else if (head.cmd.is_hash && kp_open_ff && kp_count_ff != '0) begin
               kp_done_in = 1'b1;
               kp_open_in = 1'b0;
            end
            if (kp_open_in && kp_count_in < dfbd_pkg::KEYPAD_LIMIT) begin
               kp_wr_in    = 1'b1;
               index_in    = {3'b000, kp_count_in};
               byte_in     = head.cmd.rx_byte;
               kp_count_in = kp_count_in + 1'b1;
            end
         end
         // A hash closes an empty service range without marking it done.
         if (svc_open_in && head.cmd.is_hash && svc_count_in == '0) begin
            svc_open_in = 1'b0;
         end
      end
   end

   // Result valid: set on a pop, cleared once the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         svc_open_ff  <= 1'b0;
         svc_done_ff  <= 1'b0;
         svc_count_ff <= '0;
         kp_open_ff   <= 1'b0;
         kp_done_ff   <= 1'b0;
         kp_count_ff  <= '0;
         restart_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            svc_open_ff  <= svc_open_in;
            svc_done_ff  <= svc_done_in;
            svc_count_ff <= svc_count_in;
            kp_open_ff   <= kp_open_in;
            kp_done_ff   <= kp_done_in;
            kp_count_ff  <= kp_count_in;
            restart_ff   <= restart_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         svc_wr_ff <= svc_wr_in;
         kp_wr_ff  <= kp_wr_in;
         index_ff  <= index_in;
         byte_ff   <= byte_in;
      end
   end

   // The marks reported are the frame state after the word.
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.service_write = svc_wr_ff;
   assign rsp_ch.keypad_write  = kp_wr_ff;
   assign rsp_ch.write_index   = index_ff;
   assign rsp_ch.write_byte    = byte_ff;
   assign rsp_ch.service_done  = svc_done_ff;
   assign rsp_ch.keypad_done   = kp_done_ff;
   assign rsp_ch.service_open  = svc_open_ff;
   assign rsp_ch.keypad_open   = kp_open_ff;

   // A byte goes to at most one buffer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(svc_wr_ff && kp_wr_ff))
      else $error("byte stored into both buffers");

   // Fill counts stay within the buffer limits.
   assert property (@(posedge clock) disable iff (reset)
      svc_count_ff <= dfbd_pkg::SERVICE_LIMIT && kp_count_ff <= dfbd_pkg::KEYPAD_LIMIT)
      else $error("frame count beyond limit");

   // A keypad store only happens into an open keypad frame outside a service range.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kp_wr_ff) |-> (kp_open_ff && !svc_open_ff))
      else $error("keypad store with frame closed");

   // A service store leaves the service range open.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && svc_wr_ff) |-> svc_open_ff)
      else $error("service store with range closed");

   // State only moves when a word is taken from the queue.
   assert property (@(posedge clock) disable iff (reset)
      !$past(pop) && !$past(reset) |-> $stable(svc_count_ff) && $stable(kp_count_ff))
      else $error("frame state changed without a word");

endmodule

`default_nettype wire

/* rtl/dual_frame_byte_deframer.sv */
// A word accepted into the queue has its result word registered once the back part pops it.
// Throughput: one word per cycle while the result side keeps taking result words.
// The front keeps accepting while a result waits, until the two-entry queue fills.
// Reset (synchronous, active high) closes both frames, clears done marks, counts,
// the restart request and both configuration registers, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module dual_frame_byte_deframer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   dfbd_req_if.sink                               req_ch,
   dfbd_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [dfbd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   logic               network_mode_ff, network_mode_in;
   logic               multi_service_ff, multi_service_in;
   logic               csr_write;
   logic               reg_sel;
   logic               not_full;
   logic               pop;
   dfbd_pkg::push_type push;
   dfbd_pkg::head_type head;
   dfbd_pkg::cfg_type  cfg;

   // Configuration registers, one per word address.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      network_mode_in  = network_mode_ff;
      multi_service_in = multi_service_ff;
      if (csr_write) begin
         case (reg_sel)
            dfbd_pkg::REG_NETWORK_MODE:  network_mode_in  = csr_pwdata[0];
            dfbd_pkg::REG_MULTI_SERVICE: multi_service_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         network_mode_ff  <= 1'b0;
         multi_service_ff <= 1'b0;
      end else begin
         network_mode_ff  <= network_mode_in;
         multi_service_ff <= multi_service_in;
      end
   end

   // Register read back.
   always_comb begin
      case (reg_sel)
         dfbd_pkg::REG_NETWORK_MODE:  csr_prdata = {31'b0, network_mode_ff};
         dfbd_pkg::REG_MULTI_SERVICE: csr_prdata = {31'b0, multi_service_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg.network_mode  = network_mode_ff;
   assign cfg.multi_service = multi_service_ff;

   dfbd_front u_front (
      .req_ch   (req_ch),
      .not_full (not_full),
      .push     (push)
   );

   dfbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .not_full (not_full),
      .head     (head),
      .pop      (pop)
   );

   dfbd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the dual-frame byte deframer: directed table, then random frames.
`timescale 1ns / 1ps

module tb;

   // One result word as the block reports it.
   typedef struct packed {
      logic       service_write;
      logic       keypad_write;
      logic [6:0] write_index;
      logic [7:0] write_byte;
      logic       service_done;
      logic       keypad_done;
      logic       service_open;
      logic       keypad_open;
   } frame_result_type;

   // Deframer state mirrored by the bench.
   typedef struct packed {
      logic       svc_open;
      logic       svc_done;
      logic [6:0] svc_count;
      logic       kp_open;
      logic       kp_done;
      logic [3:0] kp_count;
      logic       restart_req;
   } frame_state_type;

   typedef enum logic [1:0] {ROW_WORD, ROW_SET_NETWORK, ROW_SET_MULTI} row_kind_type;

   // A row of the directed table; typed rows carry their result word.
   typedef struct packed {
      row_kind_type     kind;
      logic             op;
      logic [7:0]       data;
      logic             typed;
      frame_result_type want;
   } stim_row_type;

   localparam int WORDS_PER_PHASE = 175;
   localparam int PHASES = 8;
   localparam int SETTLE_CYCLES = 6;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [dfbd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   dfbd_req_if req_bus ();
   dfbd_rsp_if rsp_bus ();

   dual_frame_byte_deframer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_state_type  frame_state;
   logic             net_mode_cfg;
   logic             multi_cfg;
   frame_result_type pending_results[$];
   int               mismatch_count;
   int               results_checked;
   int               words_sent;
   int               effective_words;
   int               service_stores;
   int               keypad_stores;
   int               settings_used;
   int               tx_quiet_left;

   // Directed table: extremes, both operations, and each special case in turn.
   stim_row_type directed_rows [25] = '{
      '{ROW_WORD, dfbd_pkg::OP_BYTE, 8'h00, 1'b1, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, 8'hFF, 1'b1, '0},
      '{ROW_WORD, dfbd_pkg::OP_ARM, 8'hFF, 1'b1, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, 8'h41, 1'b1,
        '{1'b0, 1'b1, 7'd0, 8'h41, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_HASH, 1'b1,
        '{1'b0, 1'b0, 7'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_HASH, 1'b0, '0},
      '{ROW_SET_NETWORK, dfbd_pkg::OP_BYTE, 8'h01, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_STAR, 1'b1,
        '{1'b0, 1'b1, 7'd0, dfbd_pkg::CH_STAR, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_DOLLAR, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, 8'h80, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_ARM, 8'h00, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_HASH, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, 8'h42, 1'b0, '0},
      '{ROW_SET_MULTI, dfbd_pkg::OP_BYTE, 8'h01, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_DOLLAR, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, 8'h7F, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_HASH, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_DOLLAR, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, 8'h01, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_DOLLAR, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_HASH, 1'b0, '0},
      '{ROW_SET_NETWORK, dfbd_pkg::OP_BYTE, 8'h00, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_STAR, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_HASH, 1'b0, '0},
      '{ROW_WORD, dfbd_pkg::OP_BYTE, dfbd_pkg::CH_STAR, 1'b0, '0}
   };

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Upper bound on the whole run.
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Works out the result word of one input word and advances the mirrored state.
   function automatic frame_result_type deframe_word(input logic op, input logic [7:0] b);
      frame_result_type r;
      r = '0;
      if (op == dfbd_pkg::OP_ARM) begin
         frame_state.restart_req = 1'b1;
      end else begin
         // A dollar sign always reopens the service range.
         if (b == dfbd_pkg::CH_DOLLAR) begin
            frame_state.svc_open  = 1'b1;
            frame_state.svc_done  = 1'b0;
            frame_state.svc_count = '0;
         end
         if (multi_cfg && frame_state.svc_open) begin
            if (b == dfbd_pkg::CH_HASH && frame_state.svc_count != 0) begin
               frame_state.svc_done = 1'b1;
               frame_state.svc_open = 1'b0;
            end
            if (frame_state.svc_open && frame_state.svc_count < dfbd_pkg::SERVICE_LIMIT) begin
               r.service_write = 1'b1;
               r.write_index   = frame_state.svc_count;
               r.write_byte    = b;
               frame_state.svc_count = frame_state.svc_count + 7'd1;
            end
         end else if (!frame_state.svc_open) begin
            // Keypad frames only move while no service range is open.
            if (frame_state.restart_req || (net_mode_cfg && b == dfbd_pkg::CH_STAR)) begin
               frame_state.restart_req = 1'b0;
               frame_state.kp_count    = '0;
               frame_state.kp_open     = 1'b1;
               frame_state.kp_done     = 1'b0;
            end else if (b == dfbd_pkg::CH_HASH && frame_state.kp_open
                         && frame_state.kp_count != 0) begin
               frame_state.kp_done = 1'b1;
               frame_state.kp_open = 1'b0;
            end
            if (frame_state.kp_open && frame_state.kp_count < dfbd_pkg::KEYPAD_LIMIT) begin
               r.keypad_write = 1'b1;
               r.write_index  = {3'b000, frame_state.kp_count};
               r.write_byte   = b;
               frame_state.kp_count = frame_state.kp_count + 4'd1;
            end
         end
         // A hash before any stored service byte closes the range with no done mark.
         if (frame_state.svc_open && b == dfbd_pkg::CH_HASH && frame_state.svc_count == 0) begin
            frame_state.svc_open = 1'b0;
         end
      end
      r.service_done = frame_state.svc_done;
      r.keypad_done  = frame_state.kp_done;
      r.service_open = frame_state.svc_open;
      r.keypad_open  = frame_state.kp_open;
      return r;
   endfunction

   // Random byte that is none of the delimiters.
   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == dfbd_pkg::CH_DOLLAR || b == dfbd_pkg::CH_HASH || b == dfbd_pkg::CH_STAR);
      return b;
   endfunction

   // Sends one word after a random gap and records its expected result once accepted.
   task automatic push_word(input logic op, input logic [7:0] b, input logic typed,
                            input frame_result_type typed_result);
      int gap;
      frame_state_type prior;
      frame_result_type r;
      if (tx_quiet_left > 0) begin
         gap = 0;
         tx_quiet_left--;
      end else if ($urandom_range(0, 24) == 0) begin
         gap = 0;
         tx_quiet_left = $urandom_range(20, 60);
      end else begin
         gap = $urandom_range(0, 10);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.rx_byte   <= b;
      do @(posedge clock); while (!req_bus.ready);
      prior = frame_state;
      r = deframe_word(op, b);
      pending_results.push_back(typed ? typed_result : r);
      words_sent++;
      if (frame_state != prior || r.service_write || r.keypad_write) effective_words++;
      if (r.service_write) service_stores++;
      if (r.keypad_write) keypad_stores++;
   endtask

   // Holds the sender off until every expected result has come back.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register over the APB port, then reads it back.
   task automatic write_setting(input logic reg_idx, input logic value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= dfbd_pkg::CSR_ADDR_W'({reg_idx, 2'b00});
      csr_pwdata  <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_idx == dfbd_pkg::REG_NETWORK_MODE) net_mode_cfg = value;
      else multi_cfg = value;
      settings_used++;
      if (readback !== {31'd0, value}) begin
         $display("%0t: register %0d read back: expected %h, actual %h",
                  $time, reg_idx, {31'd0, value}, readback);
         mismatch_count++;
      end
   endtask

   // One random sequence: mostly well-formed frames, some broken ones and noise.
   task automatic run_random_frame();
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         // Keypad frame, started by a restart request or by an asterisk.
         if (net_mode_cfg && $urandom_range(0, 1) == 1) begin
            push_word(dfbd_pkg::OP_BYTE, dfbd_pkg::CH_STAR, 1'b0, '0);
         end else begin
            push_word(dfbd_pkg::OP_ARM, 8'($urandom_range(0, 255)), 1'b0, '0);
         end
         len = $urandom_range(0, 18);
         repeat (len) push_word(dfbd_pkg::OP_BYTE, payload_byte(), 1'b0, '0);
         if ($urandom_range(0, 7) != 0) push_word(dfbd_pkg::OP_BYTE, dfbd_pkg::CH_HASH, 1'b0, '0);
      end else if (kind <= 6) begin
         // Service frame; now and then long enough to fill the buffer.
         push_word(dfbd_pkg::OP_BYTE, dfbd_pkg::CH_DOLLAR, 1'b0, '0);
         len = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 115) : $urandom_range(0, 12);
         repeat (len) push_word(dfbd_pkg::OP_BYTE, payload_byte(), 1'b0, '0);
         if ($urandom_range(0, 7) != 0) push_word(dfbd_pkg::OP_BYTE, dfbd_pkg::CH_HASH, 1'b0, '0);
      end else begin
         // Noise: stray delimiters, restart requests and arbitrary bytes.
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 5))
               0: push_word(dfbd_pkg::OP_ARM, 8'($urandom_range(0, 255)), 1'b0, '0);
               1: push_word(dfbd_pkg::OP_BYTE, dfbd_pkg::CH_HASH, 1'b0, '0);
               2: push_word(dfbd_pkg::OP_BYTE, dfbd_pkg::CH_STAR, 1'b0, '0);
               3: push_word(dfbd_pkg::OP_BYTE, dfbd_pkg::CH_DOLLAR, 1'b0, '0);
               default: push_word(dfbd_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
            endcase
         end
      end
   endtask

   // Result side: a random stall before each word, with stretches of none.
   initial begin : result_sink
      int stall;
      int quiet_left;
      quiet_left = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (quiet_left > 0) begin
            stall = 0;
            quiet_left--;
         end else if ($urandom_range(0, 24) == 0) begin
            stall = 0;
            quiet_left = $urandom_range(20, 60);
         end else begin
            stall = $urandom_range(0, 10);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   // Compares one field of a result word.
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Every accepted result word is checked against the oldest expectation.
   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result word with none expected: expected nothing, actual %h",
                     $time, {rsp_bus.service_write, rsp_bus.keypad_write,
                     rsp_bus.write_index, rsp_bus.write_byte});
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            check_field("service_write", want.service_write, rsp_bus.service_write);
            check_field("keypad_write", want.keypad_write, rsp_bus.keypad_write);
            check_field("write_index", want.write_index, rsp_bus.write_index);
            check_field("write_byte", want.write_byte, rsp_bus.write_byte);
            check_field("service_done", want.service_done, rsp_bus.service_done);
            check_field("keypad_done", want.keypad_done, rsp_bus.keypad_done);
            check_field("service_open", want.service_open, rsp_bus.service_open);
            check_field("keypad_open", want.keypad_open, rsp_bus.keypad_open);
         end
      end
   end

   // Reset, directed table, random phases under changing settings, then wrap up.
   initial begin : stimulus
      int phase_start;
      logic [1:0] setting;
      frame_state      = '0;
      net_mode_cfg     = 1'b0;
      multi_cfg        = 1'b0;
      mismatch_count   = 0;
      results_checked  = 0;
      words_sent       = 0;
      effective_words  = 0;
      service_stores   = 0;
      keypad_stores    = 0;
      settings_used    = 0;
      tx_quiet_left    = 0;
      reset             <= 1'b1;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= dfbd_pkg::OP_BYTE;
      req_bus.rx_byte   <= 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part; register rows wait for the block to go idle.
      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_WORD: begin
               push_word(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                         directed_rows[i].want);
            end
            ROW_SET_NETWORK: begin
               wait_for_results();
               write_setting(dfbd_pkg::REG_NETWORK_MODE, directed_rows[i].data[0]);
            end
            default: begin
               wait_for_results();
               write_setting(dfbd_pkg::REG_MULTI_SERVICE, directed_rows[i].data[0]);
            end
         endcase
      end

      // Random part: the four corner settings first, then random ones.
      for (int p = 0; p < PHASES; p++) begin
         setting = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
         wait_for_results();
         write_setting(dfbd_pkg::REG_NETWORK_MODE, setting[0]);
         write_setting(dfbd_pkg::REG_MULTI_SERVICE, setting[1]);
         phase_start = words_sent;
         while (words_sent - phase_start < WORDS_PER_PHASE) begin
            run_random_frame();
            if ($urandom_range(0, 39) == 0) wait_for_results();
         end
      end

      wait_for_results();
      $display("Sent %0d words (%0d moved frame state) under %0d register writes.",
               words_sent, effective_words, settings_used);
      $display("Compared %0d results; %0d service and %0d keypad stores seen.",
               results_checked, service_stores, keypad_stores);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
